// File: hdl/hsv_area_trace_classifier_defines.svh
// Assertion macros shared by the trace classifier RTL.
// Expects clk and rst to be visible at the point of use.
`ifndef HSV_AREA_TRACE_CLASSIFIER_DEFINES_SVH
`define HSV_AREA_TRACE_CLASSIFIER_DEFINES_SVH

// Same-cycle or implication check, off while in reset.
`define HATC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds in the cycle after a trigger, off while in reset.
`define HATC_CHECK_NEXT(label, trig, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (post)) else $error(msg);

`endif

// File: hdl/hatc_pkg.sv
// Types, widths and constants for the HSV trace-area classifier.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package hatc_pkg;

  localparam int unsigned AREAS_DEFAULT = 4;
  localparam int unsigned HUE_W         = 12;
  localparam int unsigned Q8_W          = 9;
  localparam int unsigned ICPT_W        = 10;
  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned SHAPE_W       = 55;
  localparam int unsigned RGB_W         = 3 * COLOR_W;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned AREA_IDX_W    = CFG_IDX_W - 1;
  localparam int unsigned SV_W          = 2 * Q8_W;
  localparam int unsigned DIFF_W        = 11;
  localparam int unsigned PROD_W        = 30;
  localparam int unsigned Q8_SHIFT      = 8;

  localparam logic [Q8_W:0] Q8_ONE = 10'd256;

  // Bit 0 of the register index picks the register kind within an area.
  localparam logic REG_KIND_SHAPE = 1'b0;
  localparam logic REG_KIND_COLOR = 1'b1;

  localparam logic [COLOR_W-1:0] PAPER_LEVEL = 8'hFF;

  typedef struct packed {
    logic signed [ICPT_W-1:0] icpt;
    logic [Q8_W-1:0]          slope;
    logic [Q8_W-1:0]          thick;
    logic [HUE_W-1:0]         hue_max;
    logic [HUE_W-1:0]         hue_min;
    logic                     full_turn;
    logic                     black;
    logic                     enable;
  } area_shape_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } area_color_t;

  // Hue window: plain, wrapped, single point or full turn.
  function automatic logic hue_in_window(area_shape_t shp, logic [HUE_W-1:0] h);
    logic ok;
    if (shp.hue_min < shp.hue_max) begin
      ok = (h >= shp.hue_min) && (h <= shp.hue_max);
    end else if (shp.hue_max < shp.hue_min) begin
      ok = !((h > shp.hue_max) && (h < shp.hue_min));
    end else begin
      ok = shp.full_turn || (h == shp.hue_min);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hatc_pixel_if.sv
// Input channel of the trace classifier: one HSV pixel per transaction.
// Uses widths from hatc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hatc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [hatc_pkg::HUE_W-1:0] hue;
  logic [hatc_pkg::Q8_W-1:0]  saturation;
  logic [hatc_pkg::Q8_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

`default_nettype wire

// File: hdl/hatc_result_if.sv
// Output channel of the trace classifier: one traced colour per transaction.
// Uses widths from hatc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hatc_result_if;
  logic                         valid;
  logic                         ready;
  logic [hatc_pkg::COLOR_W-1:0] out_red;
  logic [hatc_pkg::COLOR_W-1:0] out_green;
  logic [hatc_pkg::COLOR_W-1:0] out_blue;
  logic                         traced;

  modport source (output valid, out_red, out_green, out_blue, traced, input ready);
  modport sink (input valid, out_red, out_green, out_blue, traced, output ready);
endinterface

`default_nettype wire

// File: hdl/hatc_cfg_if.sv
// Configuration write channel of the trace classifier: register index and data.
// Uses widths from hatc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hatc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hatc_pkg::CFG_IDX_W-1:0] index;
  logic [hatc_pkg::SHAPE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/hsv_area_trace_classifier.sv
// Top level of the HSV trace-area classifier: area registers and a four-stage pipeline.
// Depends on hatc_pkg, the three channel interfaces and the defines header.
`timescale 1ns / 1ps
`default_nettype none

// Classifies one HSV pixel per clock, while the result side keeps taking results,
// against up to NUM_AREAS trace areas, area 0 first, and returns the target colour of
// the first enabled area that matches, or white with traced low. A pixel passes
// through four register stages: input pre-checks, the two black-side products per
// area, the black-side compare, and the priority select into the output register.
// Each stage stalls only when it is full and the stage after it cannot take its
// item, so empty stages keep filling while a result waits. Area registers are
// written through the cfg channel (index 2k for the shape word of area k, 2k+1 for
// its colour) and must only change while the pipeline is empty.
module hsv_area_trace_classifier #(
  parameter int unsigned NUM_AREAS = hatc_pkg::AREAS_DEFAULT
) (
  input  wire           clk,
  input  wire           rst,
  hatc_pixel_if.sink    pix,
  hatc_result_if.source res,
  hatc_cfg_if.sink      cfg
);
  import hatc_pkg::*;

`include "hsv_area_trace_classifier_defines.svh"

  area_shape_t shape [NUM_AREAS];
  area_color_t color [NUM_AREAS];

  logic                  cfg_write;
  logic [AREA_IDX_W-1:0] cfg_area;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid & cfg.ready;
  assign cfg_area  = cfg.index[CFG_IDX_W-1:1];

  for (genvar k = 0; k < NUM_AREAS; k++) begin : g_area_regs
    always_ff @(posedge clk) begin
      if (rst) begin
        shape[k] <= '0;
        color[k] <= '0;
      end else if (cfg_write && cfg_area == AREA_IDX_W'(k)) begin
        if (cfg.index[0] == REG_KIND_SHAPE) begin
          shape[k] <= area_shape_t'(cfg.data);
        end else begin
          color[k] <= area_color_t'(cfg.data[RGB_W-1:0]);
        end
      end
    end
  end

  // Pipeline flow control
  logic valid1, valid2, valid3, valid4;
  logic adv1, adv2, adv3, adv4;

  assign adv4      = !valid4 || res.ready;
  assign adv3      = !valid3 || adv4;
  assign adv2      = !valid2 || adv3;
  assign adv1      = !valid1 || adv2;
  assign pix.ready = adv1;

  // Stage 1: s*v, the per-area checks that need no product, and 256-v-I
  logic [SV_W-1:0]          sv_in;
  logic [NUM_AREAS-1:0]     pre_in;
  logic signed [DIFF_W-1:0] d_in [NUM_AREAS];

  assign sv_in = SV_W'(pix.saturation) * SV_W'(pix.brightness);

  always_comb begin
    logic [Q8_W:0] ts;
    logic          col_ok;
    for (int k = 0; k < NUM_AREAS; k++) begin
      // thick >= 256 - s, taken as signed, is thick + s >= 256
      ts     = {1'b0, shape[k].thick} + {1'b0, pix.saturation};
      col_ok = hue_in_window(shape[k], pix.hue) && (ts >= Q8_ONE)
               && (pix.brightness != '0) && (pix.saturation != '0);
      pre_in[k] = shape[k].enable
                  && (shape[k].black ? (shape[k].thick >= pix.brightness) : col_ok);
      d_in[k]   = DIFF_W'(Q8_ONE) - DIFF_W'(pix.brightness) - DIFF_W'(shape[k].icpt);
    end
  end

  logic [SV_W-1:0]          sv1;
  logic [NUM_AREAS-1:0]     pre1;
  logic signed [DIFF_W-1:0] d1 [NUM_AREAS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv1) begin
      valid1 <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sv1  <= sv_in;
      pre1 <= pre_in;
      d1   <= d_in;
    end
  end

  // Stage 2: (256-L)*sv and (256-v-I)*L per area
  logic signed [PROD_W-1:0] lhs_in [NUM_AREAS];
  logic signed [PROD_W-1:0] rhs_in [NUM_AREAS];

  always_comb begin
    logic signed [Q8_W:0] lneg;
    for (int k = 0; k < NUM_AREAS; k++) begin
      lneg      = $signed(Q8_ONE - {1'b0, shape[k].slope});
      lhs_in[k] = PROD_W'(lneg) * $signed(PROD_W'(sv1));
      rhs_in[k] = PROD_W'(d1[k]) * $signed(PROD_W'(shape[k].slope));
    end
  end

  logic signed [PROD_W-1:0] lhs2 [NUM_AREAS];
  logic signed [PROD_W-1:0] rhs2 [NUM_AREAS];
  logic [NUM_AREAS-1:0]     pre2;
  logic                     svz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      lhs2 <= lhs_in;
      rhs2 <= rhs_in;
      pre2 <= pre1;
      svz2 <= (sv1 == '0);
    end
  end

  // Stage 3: black-side compare and per-area match
  logic [NUM_AREAS-1:0] match_in;

  always_comb begin
    logic side;
    for (int k = 0; k < NUM_AREAS; k++) begin
      side = svz2 || ((shape[k].slope != '0) && (lhs2[k] < (rhs2[k] <<< Q8_SHIFT)));
      match_in[k] = pre2[k] && (shape[k].black ? side : !side);
    end
  end

  logic [NUM_AREAS-1:0] match3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (adv3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      match3 <= match_in;
    end
  end

  // Stage 4: lowest matching area wins, else white paper
  area_color_t pick;
  logic        hit;

  always_comb begin
    pick = '{red: PAPER_LEVEL, green: PAPER_LEVEL, blue: PAPER_LEVEL};
    hit  = 1'b0;
    for (int k = NUM_AREAS - 1; k >= 0; k--) begin
      if (match3[k]) begin
        pick = color[k];
        hit  = 1'b1;
      end
    end
  end

  area_color_t out_color;
  logic        out_traced;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
    end else if (adv4) begin
      valid4 <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_color  <= pick;
      out_traced <= hit;
    end
  end

  assign res.valid     = valid4;
  assign res.out_red   = out_color.red;
  assign res.out_green = out_color.green;
  assign res.out_blue  = out_color.blue;
  assign res.traced    = out_traced;

  `HATC_CHECK(a_untraced_is_white, res.valid && !res.traced |-> res.out_red == PAPER_LEVEL && res.out_green == PAPER_LEVEL && res.out_blue == PAPER_LEVEL, "untraced result is not white paper")
  `HATC_CHECK(a_output_fed_by_stage3, $rose(valid4) |-> $past(valid3), "output valid rose without an item in stage 3")
  `HATC_CHECK_NEXT(a_stage3_holds, valid3 && !adv3, valid3 && $stable(match3), "stalled stage 3 lost its match vector")
  `HATC_CHECK(a_empty_front_accepts, !valid1 |-> pix.ready, "empty first stage refused a pixel")

endmodule

`default_nettype wire

// File: sim/hsv_area_trace_classifier_tb.sv
// Testbench for hsv_area_trace_classifier: random and directed HSV pixels checked against a
// local predictor of the four trace areas. Depends on hatc_pkg and the three channel
// interfaces (hatc_pixel_if, hatc_result_if, hatc_cfg_if).
`timescale 1ns / 1ps

module hsv_area_trace_classifier_tb;
  import hatc_pkg::*;

  localparam int AREA_COUNT  = AREAS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 10;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [Q8_W-1:0]  saturation;
    logic [Q8_W-1:0]  brightness;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               traced;
  } trace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hatc_pixel_if  pix ();
  hatc_result_if res ();
  hatc_cfg_if    cfg ();

  hsv_area_trace_classifier #(.NUM_AREAS(AREA_COUNT)) dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  // Shadow copy of the area registers, updated on each cfg transaction.
  area_shape_t shape_regs [AREA_COUNT];
  area_color_t color_regs [AREA_COUNT];

  pixel_t pixels_to_send [$];
  trace_t colors_due [$];
  pixel_t next_px;

  int send_idle_pct = 31;
  int recv_stall_pct = 78;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  bit pix_taken = 1'b0;

  int errors = 0;
  int cycle_count = 0;
  int pixels_sent = 0;
  int traced_seen = 0;
  int paper_seen = 0;
  int settings_applied = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Black side of the slanted cut: (256-L)*s*v < (256-v-I)*L*256, exact signed.
  function automatic bit black_side(longint s, longint v, longint slope, longint icpt);
    longint sv;
    sv = s * v;
    if (sv == 0) return 1'b1;
    if (slope == 0) return 1'b0;
    return (256 - slope) * sv < (256 - v - icpt) * slope * 256;
  endfunction

  function automatic bit area_hit(area_shape_t a, pixel_t px);
    longint h, s, v, lo, hi, thick, slope, icpt;
    bit hue_ok;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    lo = a.hue_min;
    hi = a.hue_max;
    thick = a.thick;
    slope = a.slope;
    icpt = $signed(a.icpt);
    if (a.black) return (thick >= v) && (v == 0 || s == 0 || black_side(s, v, slope, icpt));
    if (lo < hi) hue_ok = (h >= lo) && (h <= hi);
    else if (hi < lo) hue_ok = !((h > hi) && (h < lo));
    else hue_ok = a.full_turn || (h == lo);
    return hue_ok && (thick >= 256 - s) && (v > 0) && (s > 0) &&
           !black_side(s, v, slope, icpt);
  endfunction

  function automatic trace_t classify_pixel(pixel_t px);
    trace_t t;
    t = '{red: PAPER_LEVEL, green: PAPER_LEVEL, blue: PAPER_LEVEL, traced: 1'b0};
    // scan downwards so the lowest matching area wins
    for (int k = AREA_COUNT - 1; k >= 0; k--) begin
      if (shape_regs[k].enable && area_hit(shape_regs[k], px)) begin
        t = '{red: color_regs[k].red, green: color_regs[k].green,
              blue: color_regs[k].blue, traced: 1'b1};
      end
    end
    return t;
  endfunction

  function automatic area_shape_t random_shape();
    area_shape_t a;
    a.enable = ($urandom_range(9) != 0);
    a.black = ($urandom_range(3) == 0);
    a.full_turn = 1'($urandom_range(1));
    a.hue_min = 12'($urandom_range(3600));
    case ($urandom_range(3))
      0: a.hue_max = a.hue_min;
      1: a.hue_max = 12'($urandom_range(4095));
      default: a.hue_max = 12'($urandom_range(3600));
    endcase
    a.thick = ($urandom_range(7) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(256));
    a.slope = ($urandom_range(7) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(256));
    if ($urandom_range(1)) a.icpt = 10'($urandom_range(1023));
    else a.icpt = 10'($urandom_range(255)) - 10'd128;
    return a;
  endfunction

  // Bias toward hue and thickness edges of a randomly picked area, and toward field extremes.
  function automatic pixel_t random_pixel();
    pixel_t px;
    area_shape_t a;
    int pick;
    pick = $urandom_range(99);
    a = shape_regs[AREA_IDX_W'($urandom_range(AREA_COUNT - 1))];
    px.hue = 12'($urandom_range(3600));
    px.saturation = 9'($urandom_range(256));
    px.brightness = 9'($urandom_range(256));
    if (pick < 10) begin
      px = pixel_t'({12'($urandom()), 9'($urandom()), 9'($urandom())});
    end else if (pick < 35) begin
      px.hue = (pick[0] ? a.hue_min : a.hue_max) + 12'($urandom_range(2)) - 12'd1;
    end else if (pick < 45) begin
      px.saturation = pick[0] ? 9'd256 : 9'd0;
      px.brightness = pick[1] ? 9'd256 : 9'($urandom_range(1));
    end else if (pick < 55) begin
      px.brightness = a.thick + 9'($urandom_range(2)) - 9'd1;
      px.saturation = 9'd256 - a.thick + 9'($urandom_range(2)) - 9'd1;
    end
    return px;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SHAPE_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_area(int k, area_shape_t shp, area_color_t col);
    write_reg({AREA_IDX_W'(k), REG_KIND_SHAPE}, shp);
    write_reg({AREA_IDX_W'(k), REG_KIND_COLOR}, SHAPE_W'(col));
  endtask

  task automatic randomize_areas();
    for (int k = 0; k < AREA_COUNT; k++) load_area(k, random_shape(), area_color_t'($urandom()));
    settings_applied++;
  endtask

  task automatic add_pixel(logic [HUE_W-1:0] h, logic [Q8_W-1:0] s, logic [Q8_W-1:0] v);
    pixels_to_send.push_back('{hue: h, saturation: s, brightness: v});
  endtask

  task automatic add_random_pixels(int n);
    repeat (n) pixels_to_send.push_back(random_pixel());
  endtask

  // Wait until every pixel went in and every result came out, then let the pipe settle.
  task automatic drain();
    do @(posedge clk); while (pixels_to_send.size() != 0 || pix.valid || colors_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Pixel driver: advance only once the current transaction has gone through.
  always @(negedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_taken) begin
      if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_px = pixels_to_send.pop_front();
        pix.valid <= 1'b1;
        pix.hue <= next_px.hue;
        pix.saturation <= next_px.saturation;
        pix.brightness <= next_px.brightness;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus long hold-offs on request.
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: track config, predict on each pixel transaction, check each result.
  always @(posedge clk) begin
    trace_t want;
    if (rst) begin
      pix_taken = 1'b0;
    end else begin
      pix_taken = pix.valid && pix.ready;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index[0] == REG_KIND_SHAPE) begin
          shape_regs[cfg.index[CFG_IDX_W-1:1]] = area_shape_t'(cfg.data);
        end else begin
          color_regs[cfg.index[CFG_IDX_W-1:1]] = area_color_t'(cfg.data[RGB_W-1:0]);
        end
      end
      if (pix_taken) begin
        colors_due.push_back(classify_pixel('{hue: pix.hue, saturation: pix.saturation,
                                              brightness: pix.brightness}));
        pixels_sent++;
      end
      if (res.valid && res.ready) begin
        if (colors_due.size() == 0) begin
          $error("result transaction with no pixel pending");
          errors++;
        end else begin
          want = colors_due.pop_front();
          check_field("out_red", int'(want.red), int'(res.out_red));
          check_field("out_green", int'(want.green), int'(res.out_green));
          check_field("out_blue", int'(want.blue), int'(res.out_blue));
          check_field("traced", int'(want.traced), int'(res.traced));
          if (res.traced) traced_seen++;
          else paper_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsv_area_trace_classifier_tb NOT OK");
      $finish;
    end
  end

  initial begin
    pix.valid = 1'b0;
    pix.hue = '0;
    pix.saturation = '0;
    pix.brightness = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    for (int k = 0; k < AREA_COUNT; k++) begin
      shape_regs[k] = '0;
      color_regs[k] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // All areas disabled after reset: everything is paper.
    add_pixel(12'd0, 9'd0, 9'd0);
    add_pixel(12'd3600, 9'd256, 9'd256);
    add_pixel(12'd4095, 9'd511, 9'd511);
    drain();

    // Directed areas: black line with full turn set, plain range with full turn set,
    // wrapped range, single point taking the full turn with no slope.
    load_area(0, '{icpt: 10'sd0, slope: 9'd128, thick: 9'd64, hue_max: 12'd0, hue_min: 12'd0,
                   full_turn: 1'b1, black: 1'b1, enable: 1'b1}, 24'h102030);
    load_area(1, '{icpt: -10'sd32, slope: 9'd64, thick: 9'd128, hue_max: 12'd600,
                   hue_min: 12'd0, full_turn: 1'b1, black: 1'b0, enable: 1'b1}, 24'hC00000);
    load_area(2, '{icpt: 10'sd100, slope: 9'd200, thick: 9'd256, hue_max: 12'd300,
                   hue_min: 12'd3000, full_turn: 1'b0, black: 1'b0, enable: 1'b1}, 24'h00C000);
    load_area(3, '{icpt: 10'sd0, slope: 9'd0, thick: 9'd256, hue_max: 12'd1800,
                   hue_min: 12'd1800, full_turn: 1'b1, black: 1'b0, enable: 1'b1}, 24'h0000C0);
    settings_applied++;
    add_pixel(12'd0, 9'd0, 9'd0);
    add_pixel(12'd3600, 9'd256, 9'd256);
    add_pixel(12'd4095, 9'd511, 9'd511);
    add_pixel(12'd0, 9'd256, 9'd0);
    add_pixel(12'd0, 9'd0, 9'd256);
    add_pixel(12'd300, 9'd200, 9'd200);
    add_pixel(12'd600, 9'd256, 9'd128);
    add_pixel(12'd601, 9'd256, 9'd128);
    add_pixel(12'd3000, 9'd256, 9'd200);
    add_pixel(12'd2999, 9'd256, 9'd200);
    add_pixel(12'd1800, 9'd128, 9'd128);
    add_pixel(12'd1799, 9'd128, 9'd128);
    add_pixel(12'd100, 9'd30, 9'd40);
    add_pixel(12'd0, 9'd1, 9'd1);
    add_pixel(12'd3600, 9'd256, 9'd1);
    add_pixel(12'd2048, 9'd255, 9'd255);
    add_pixel(12'd1, 9'd511, 9'd64);
    add_pixel(12'd0, 9'd0, 9'd511);
    drain();

    // Random areas; hold the receiver off long enough to back the pipe up.
    randomize_areas();
    add_random_pixels(200);
    while (pixels_to_send.size() > 150) @(posedge clk);
    holds_asked++;
    drain();

    send_idle_pct = 78;
    recv_stall_pct = 31;
    randomize_areas();
    add_random_pixels(100);
    drain();
    add_random_pixels(100);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < AREA_COUNT; k++) load_area(k, '1, 24'hFFFFFF);
    settings_applied++;
    add_random_pixels(40);
    drain();
    randomize_areas();
    add_random_pixels(120);
    drain();
    for (int k = 0; k < AREA_COUNT; k++) load_area(k, '0, 24'h000000);
    settings_applied++;
    add_random_pixels(20);
    drain();

    $display("checked %0d pixels over %0d area settings: %0d traced, %0d paper",
             pixels_sent, settings_applied, traced_seen, paper_seen);
    $display("stimulus covered black and colour areas, all hue window kinds, and out-of-range fields");
    if (errors == 0) begin
      $display("hsv_area_trace_classifier_tb OK");
    end else begin
      $display("hsv_area_trace_classifier_tb NOT OK");
    end
    $finish;
  end

endmodule
